// ===== hdl/mag_sdq_pkg.sv =====
// Shared types and constants for the magnetometer sample duplicate qualifier.
// No dependencies; imported by the top level, the port checker and the testbench.
package mag_sdq_pkg;

    // Field widths
    localparam int unsigned STATUS_W = 8;
    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned SAMPLE_W = 3 * AXIS_W;

    // Stream packing: input 88 bits (11 bytes), output 51 bits padded to 56
    localparam int unsigned S_TDATA_W = STATUS_W + SAMPLE_W + TIME_W;
    localparam int unsigned M_USED_W  = 1 + 2 + SAMPLE_W;
    localparam int unsigned M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // Register indexes (byte address = 4 * index)
    typedef enum logic {
        REG_PERIOD      = 1'b0,
        REG_SKIP_STATUS = 1'b1
    } t_reg_idx;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);

    // Status byte bits
    localparam int unsigned STAT_READY_BIT    = 0;
    localparam int unsigned STAT_OVERFLOW_BIT = 1;

    // Reason codes
    typedef enum logic [1:0] {
        WHY_OK        = 2'd0,
        WHY_NOT_READY = 2'd1,
        WHY_OVERFLOW  = 2'd2,
        WHY_DUPLICATE = 2'd3
    } t_why;

    // p/10 == (p*205) >> 11, exact for every 10-bit p
    localparam int unsigned TENTH_MUL   = 205;
    localparam int unsigned TENTH_SHIFT = 11;

endpackage

// ===== hdl/mag_sample_duplicate_qualifier.sv =====
// Magnetometer sample duplicate qualifier: status check, duplicate timing, result register.
// Depends on mag_sdq_pkg.
//
//  channel   | dir | handshake                     | payload (lsb first)
//  ----------+-----+-------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | status, axis_x, axis_y, axis_z, now_ms
//  m_axis    | out | m_axis_tvalid / m_axis_tready | accepted, why, out_x, out_y, out_z
//  apb       | in  | psel & penable & pwrite       | period_ms @0x0, skip_status @0x4
//
// One item per cycle unless the output stalls; items pass the input, then the result register.
// The decision and the kept-sample update happen as an item moves from the input
// register into the result register, so the next item already sees the new state.
// With the result stalled one more item is still taken into the input register.
// Reset (synchronous, active low) empties both stages, clears the kept sample and
// time, and loads period_ms = 20, skip_status = 0. pready is tied high.
module mag_sample_duplicate_qualifier
    import mag_sdq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // stream in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // status[7:0], axis_x[23:8], axis_y[39:24],
                                                // axis_z[55:40], now_ms[87:56]
    // stream out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // accepted[0], why[2:1], out_x[18:3],
                                                // out_y[34:19], out_z[50:35], zero[55:51]
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // ---------------- configuration registers ----------------
    logic [PERIOD_W-1:0] r_period;
    logic                r_skip_status;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);   // low address bits ignored

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_RESET;
            r_skip_status <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PERIOD:      r_period      <= pwdata[PERIOD_W-1:0];
                REG_SKIP_STATUS: r_skip_status <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PERIOD:      prdata = {{(PDATA_W-PERIOD_W){1'b0}}, r_period};
            REG_SKIP_STATUS: prdata = {{(PDATA_W-1){1'b0}}, r_skip_status};
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;   // result register can take a new item this cycle
    logic advance;    // input register moves into result register
    logic in_take;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // ---------------- input register ----------------
    logic [STATUS_W-1:0] r_in_status;
    logic [SAMPLE_W-1:0] r_in_sample;   // x lowest, then y, then z
    logic [TIME_W-1:0]   r_in_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_status <= s_axis_tdata[STATUS_W-1:0];
            r_in_sample <= s_axis_tdata[STATUS_W +: SAMPLE_W];
            r_in_now    <= s_axis_tdata[STATUS_W+SAMPLE_W +: TIME_W];
        end
    end

    // ---------------- kept sample state ----------------
    logic [SAMPLE_W-1:0] r_prior_sample;
    logic                r_prior_valid;
    logic [TIME_W-1:0]   r_prior_time;

    // ---------------- decision logic ----------------
    logic [PERIOD_W+8-1:0] tenth_prod;
    logic [PERIOD_W:0]     limit;        // period + period/10
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W-1:0]     stepped_time; // kept time advanced by one period
    logic [TIME_W-1:0]     lag;
    logic                  same_sample;
    logic                  too_soon;
    logic                  far_behind;
    t_why                  why;
    logic                  accept;
    logic [TIME_W-1:0]     n_prior_time;

    always_comb begin
        tenth_prod   = (PERIOD_W+8)'(r_period) * (PERIOD_W+8)'(TENTH_MUL);
        limit        = {1'b0, r_period}
                     + (PERIOD_W+1)'(tenth_prod[PERIOD_W+8-1:TENTH_SHIFT]);
        elapsed      = r_in_now - r_prior_time;
        too_soon     = elapsed < TIME_W'(limit);
        stepped_time = r_prior_time + TIME_W'(r_period);
        lag          = r_in_now - stepped_time;
        far_behind   = lag > TIME_W'({r_period, 1'b0});
        same_sample  = r_prior_valid && (r_in_sample == r_prior_sample);

        // not ready wins over overflow
        if (!r_skip_status && !r_in_status[STAT_READY_BIT]) begin
            why = WHY_NOT_READY;
        end else if (!r_skip_status && r_in_status[STAT_OVERFLOW_BIT]) begin
            why = WHY_OVERFLOW;
        end else if (same_sample && too_soon) begin
            why = WHY_DUPLICATE;
        end else begin
            why = WHY_OK;
        end
        accept = (why == WHY_OK);

        // fresh sample or far-behind duplicate resyncs to now; a late duplicate steps one period
        if (same_sample && !far_behind) begin
            n_prior_time = stepped_time;
        end else begin
            n_prior_time = r_in_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_valid  <= 1'b0;
            r_prior_sample <= '0;
            r_prior_time   <= '0;
        end else if (advance && accept) begin
            r_prior_valid  <= 1'b1;
            r_prior_sample <= r_in_sample;
            r_prior_time   <= n_prior_time;
        end
    end

    // ---------------- result register ----------------
    logic [M_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            // rejected items carry zero counts
            r_out_data <= {{(M_TDATA_W-M_USED_W){1'b0}},
                           (accept ? r_in_sample : {SAMPLE_W{1'b0}}),
                           why, accept};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== hdl/mag_sdq_checker.sv =====
// Port-level checker for mag_sample_duplicate_qualifier, with its bind.
// Depends on mag_sdq_pkg.
module mag_sdq_checker
    import mag_sdq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // accepted items carry reason OK, rejected ones a nonzero reason and zero counts
    a_accept_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == WHY_OK)))
        else $error("accept flag and reason disagree");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[M_TDATA_W-1:3] == '0))
        else $error("rejected item carries nonzero counts or padding");

    // an empty result stage always leaves room for a new item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while result stage empty");

    // every new result traces back to an item offered on the input beforehand
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 2) || $past(s_axis_tvalid, 1))
        else $error("result appeared without an input item");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind mag_sample_duplicate_qualifier mag_sdq_checker u_mag_sdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/mag_sample_duplicate_qualifier_tb.sv =====
// Self-checking testbench for the magnetometer sample duplicate qualifier.
// Streams readings in, predicts every verdict in-house and checks the output stream.
// Depends on mag_sdq_pkg and mag_sample_duplicate_qualifier.
`timescale 1ns / 1ps

module mag_sample_duplicate_qualifier_tb;
    import mag_sdq_pkg::*;

    localparam int unsigned RUN_LIMIT   = 400000;  // cycles before declaring a hang
    localparam int unsigned HOLD_CYCLES = 300;     // long receiver stall
    localparam int unsigned SEG_ITEMS   = 230;     // random items per config setting

    // One verdict as carried on the output stream
    typedef struct packed {
        logic              accepted;
        t_why              why;
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
        logic [AXIS_W-1:0] z;
    } t_verdict;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data  = '0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic                 m_ready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mag_sample_duplicate_qualifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),   // status, axis_x, axis_y, axis_z, now_ms
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // accepted, why, out_x, out_y, out_z, zero pad
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the registers and kept sample
    // ---------------------------------------------------------------
    logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;
    logic                cfg_skip   = 1'b0;
    logic [SAMPLE_W-1:0] kept_sample = '0;
    logic                kept_valid  = 1'b0;
    logic [TIME_W-1:0]   kept_time   = '0;

    logic [S_TDATA_W-1:0] pending_readings[$];  // items not yet offered
    t_verdict             verdicts_due[$];      // predictions awaiting output
    int unsigned          items_queued = 0;     // bumped by the sequencer
    int unsigned          items_taken  = 0;     // bumped on each input handshake
    int unsigned          mismatches   = 0;
    int unsigned          cycles       = 0;
    logic                 in_fire      = 1'b0;

    // Idle percentages and long-stall request, written by the sequencer only
    int unsigned tx_idle_pct = 11;
    int unsigned rx_idle_pct = 79;
    int unsigned hold_req    = 0;

    // Generator's running notion of time and of the last sample it produced
    logic [TIME_W-1:0] gen_now = '0;
    logic [AXIS_W-1:0] gen_x = '0, gen_y = '0, gen_z = '0;

    // Verdict for one reading taken at the input; advances the kept sample/time state.
    task automatic qualify_reading(input logic [S_TDATA_W-1:0] d, output t_verdict v);
        logic [STATUS_W-1:0] st;
        logic [AXIS_W-1:0]   ax, ay, az;
        logic [TIME_W-1:0]   now, p32, elapsed, lim;
        logic [SAMPLE_W-1:0] smp;
        logic                too_soon;
        st  = d[7:0];
        ax  = d[23:8];
        ay  = d[39:24];
        az  = d[55:40];
        now = d[87:56];
        smp = {az, ay, ax};
        p32 = TIME_W'(cfg_period);
        v   = '{accepted: 1'b0, why: WHY_OK, x: '0, y: '0, z: '0};
        too_soon = 1'b0;
        // not-ready wins over overflow when both are flagged
        if (!cfg_skip && !st[STAT_READY_BIT]) begin
            v.why = WHY_NOT_READY;
        end else if (!cfg_skip && st[STAT_OVERFLOW_BIT]) begin
            v.why = WHY_OVERFLOW;
        end else begin
            if (kept_valid && smp == kept_sample) begin
                elapsed = now - kept_time;      // wraps: time going back looks late
                lim     = p32 + p32 / 10;
                if (elapsed < lim) begin
                    too_soon = 1'b1;
                end else begin
                    kept_time = kept_time + p32;
                    if (now - kept_time > p32 * 2)
                        kept_time = now;        // fell too far behind, resync
                end
            end else begin
                kept_time = now;
            end
            if (too_soon) begin
                v.why = WHY_DUPLICATE;
            end else begin
                kept_sample = smp;
                kept_valid  = 1'b1;
                v.accepted  = 1'b1;
                v.x = ax;
                v.y = ay;
                v.z = az;
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_verdict want, input t_verdict got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("mismatch (%s): want acc=%0d why=%0d x=%h y=%h z=%h, ",
                   what, want.accepted, want.why, want.x, want.y, want.z);
            $display("got acc=%0d why=%0d x=%h y=%h z=%h",
                     got.accepted, got.why, got.x, got.y, got.z);
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: offers the next pending item at the falling edge. A held
    // item stays put until its handshake is seen.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        logic                 nv;
        logic [S_TDATA_W-1:0] nd;
        nv = s_valid;
        nd = s_data;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_valid || in_fire) begin
            nv = 1'b0;
            if (pending_readings.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nd = pending_readings.pop_front();
                nv = 1'b1;
            end
        end
        s_valid <= nv;
        s_data  <= nd;
    end

    // Receiver ready: random stalls, plus a long hold-off on request
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    always @(negedge i_clk) begin
        logic rdy;
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rdy = 1'b0;
        end else begin
            rdy = ($urandom_range(99) >= rx_idle_pct);
        end
        m_ready <= rdy;
    end

    // ---------------------------------------------------------------
    // Monitor: checks results against the oldest prediction, then
    // predicts for any item taken at this edge. Also the hang guard.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict got, want;
        cycles++;
        in_fire <= i_rst_n && s_valid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_ready) begin
                got.accepted = m_axis_tdata[0];
                got.why      = t_why'(m_axis_tdata[2:1]);
                got.x        = m_axis_tdata[18:3];
                got.y        = m_axis_tdata[34:19];
                got.z        = m_axis_tdata[50:35];
                if (verdicts_due.size() == 0) begin
                    note_mismatch("unexpected", '0, got);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.accepted !== want.accepted || got.why !== want.why ||
                        got.x !== want.x || got.y !== want.y || got.z !== want.z)
                        note_mismatch("result", want, got);
                end
            end
            if (s_valid && s_axis_tready) begin
                qualify_reading(s_data, want);
                verdicts_due.push_back(want);
                items_taken++;
            end
        end
        if (cycles > RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer helpers
    // ---------------------------------------------------------------
    task automatic push_reading(input logic [7:0] st, input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z, input logic [31:0] t);
        pending_readings.push_back({t, z, y, x, st});
        items_queued++;
    endtask

    // Block until every queued item is in and every verdict is out
    task automatic settle();
        while (items_taken != items_queued || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Setup cycle then access cycle; pready is tied high
    task automatic apb_xfer(input logic wr, input t_reg_idx idx, input logic [PDATA_W-1:0] wd,
                            output logic [PDATA_W-1:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_readback(input t_reg_idx idx);
        logic [PDATA_W-1:0] rd, want;
        want = (idx == REG_PERIOD) ? PDATA_W'(cfg_period) : PDATA_W'(cfg_skip);
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch (register %0d read): want %h, got %h", idx, want, rd);
        end
    endtask

    task automatic set_config(input logic [PERIOD_W-1:0] period, input logic skip);
        logic [PDATA_W-1:0] rd;
        settle();
        apb_xfer(1'b1, REG_PERIOD, PDATA_W'(period), rd);
        cfg_period = period;
        apb_xfer(1'b1, REG_SKIP_STATUS, PDATA_W'(skip), rd);
        cfg_skip = skip;
        reg_readback(REG_PERIOD);
        reg_readback(REG_SKIP_STATUS);
    endtask

    // Mostly good-status readings, many repeating the last sample, with time steps
    // clustered around the duplicate window; the rest fresh samples and noise.
    task automatic queue_random_readings(input int count);
        int          pick, delta, lim, p;
        logic [7:0]  st;
        for (int k = 0; k < count; k++) begin
            p    = int'(cfg_period);
            lim  = p + p / 10;
            pick = $urandom_range(99);
            if (pick < 30)
                delta = int'($urandom_range(3));
            else if (pick < 60)
                delta = lim + int'($urandom_range(4)) - 2;     // edge of the window
            else if (pick < 85)
                delta = int'($urandom_range(3 * p + 3));
            else if (pick < 93)
                delta = 2 * p + int'($urandom_range(2 * p + 2)); // around resync point
            else
                delta = int'($urandom);                          // wraps, may go back
            gen_now = gen_now + 32'(delta);

            pick = $urandom_range(99);
            if (pick < 10) begin
                gen_y = 16'($urandom);                           // one axis differs
            end else if (pick >= 55) begin
                gen_x = 16'($urandom);
                gen_y = 16'($urandom);
                gen_z = 16'($urandom);
            end
            st = 8'($urandom);
            if ($urandom_range(99) < 88) begin
                st[STAT_READY_BIT]    = 1'b1;
                st[STAT_OVERFLOW_BIT] = 1'b0;
            end
            push_reading(st, gen_x, gen_y, gen_z, gen_now);
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    logic [PERIOD_W-1:0] seg_period[6] = '{10'd1, 10'd1000, 10'd20, 10'd0, 10'd37, 10'd1023};
    logic                seg_skip[6]   = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of both registers
        reg_readback(REG_PERIOD);
        reg_readback(REG_SKIP_STATUS);

        // Directed, reset config (period 20 -> duplicate window 22 ms)
        push_reading(8'h00, 16'd1, 16'd2, 16'd3, 32'd10);      // not ready
        push_reading(8'h02, 16'd1, 16'd2, 16'd3, 32'd10);      // not ready wins over overflow
        push_reading(8'h03, 16'd1, 16'd2, 16'd3, 32'd10);      // overflow
        push_reading(8'hFF, 16'd1, 16'd2, 16'd3, 32'd10);      // overflow, high bits set
        push_reading(8'h01, 16'h0000, 16'h0000, 16'h0000, 32'd0);  // zero, nothing kept yet
        push_reading(8'h01, 16'h0000, 16'h0000, 16'h0000, 32'd21); // duplicate too soon
        push_reading(8'hFD, 16'h0000, 16'h0000, 16'h0000, 32'd22); // just late enough
        push_reading(8'h01, 16'h8000, 16'h7FFF, 16'hFFFF, 32'd23);
        push_reading(8'h01, 16'h8000, 16'h7FFF, 16'hFFFF, 32'd44);
        push_reading(8'h01, 16'h8000, 16'h7FFF, 16'hFFFF, 32'd45);
        push_reading(8'h01, 16'h8000, 16'h7FFF, 16'hFFFF, 32'd5000);  // far behind, resync
        push_reading(8'h01, 16'h8000, 16'h7FFF, 16'hFFFF, 32'd100);   // time goes back
        push_reading(8'h01, 16'h7FFF, 16'h8000, 16'h0001, 32'hFFFF_FFF0);
        push_reading(8'h01, 16'h7FFF, 16'h8000, 16'h0001, 32'h0000_0005); // across wrap
        push_reading(8'h01, 16'h7FFF, 16'h8000, 16'h0001, 32'h0000_0006);

        // Period zero: duplicates always pass; status ignored
        set_config(10'd0, 1'b1);
        push_reading(8'h00, 16'd5, 16'd5, 16'd5, 32'd200);
        push_reading(8'h02, 16'd5, 16'd5, 16'd5, 32'd200);
        push_reading(8'hFE, 16'd5, 16'd5, 16'd5, 32'd150);
        push_reading(8'h00, 16'd5, 16'd5, 16'd5, 32'd150);

        // Largest period
        set_config(10'd1023, 1'b0);
        push_reading(8'h01, 16'd9, 16'd9, 16'd9, 32'd1000);
        push_reading(8'h01, 16'd9, 16'd9, 16'd9, 32'd2124);   // one short of the window
        push_reading(8'h01, 16'd9, 16'd9, 16'd9, 32'd2125);

        // Random segments: idle pattern changes every two settings
        for (int seg = 0; seg < 6; seg++) begin
            set_config(seg_period[seg], seg_skip[seg]);
            if (seg < 2) begin
                tx_idle_pct = 11;
                rx_idle_pct = 79;
            end else if (seg < 4) begin
                tx_idle_pct = 79;
                rx_idle_pct = 11;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            queue_random_readings(SEG_ITEMS);
            // long output stall with the sender streaming flat out
            if (seg == 4)
                hold_req = hold_req + 1;
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
